// File: rtl/source_token_scanner_core_defines.svh
// Assertion macros shared by the source token scanner RTL.
`ifndef SOURCE_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define STS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property that also holds during reset.
`define STS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STS_ASSERT(lbl, prop, msg)
`define STS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/sts_pkg.sv
// Types, constants and character helpers of the source token scanner.
package sts_pkg;

  localparam int MAX_TEXT = 32;
  localparam int LINE_W   = 16;
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int IDX_W    = $clog2(MAX_TEXT);
  localparam int INT_W    = 31;
  localparam int KW_NUM   = 8;

  typedef enum logic [5:0] {
    TK_ERROR = 6'd0, TK_IDENT = 6'd1, TK_STRING = 6'd2, TK_INTEGER = 6'd3,
    TK_DO = 6'd4, TK_BEGIN = 6'd5, TK_END = 6'd6, TK_IF = 6'd7, TK_THEN = 6'd8,
    TK_ELSE = 6'd9, TK_DEF = 6'd10, TK_LET = 6'd11,
    TK_BOF = 6'd12, TK_EOL = 6'd13, TK_EOF = 6'd14,
    TK_LPAR = 6'd15, TK_RPAR = 6'd16, TK_COLON = 6'd17, TK_COMMA = 6'd18,
    TK_PIPE = 6'd19, TK_ASSIGN = 6'd20, TK_LQUOTE = 6'd21, TK_RQUOTE = 6'd22,
    TK_PLUS = 6'd23, TK_MINUS = 6'd24, TK_STAR = 6'd25, TK_SLASH = 6'd26,
    TK_EQUAL = 6'd27, TK_NOTEQ = 6'd28, TK_LESS = 6'd29, TK_GREATER = 6'd30,
    TK_LESSEQ = 6'd31, TK_GREATEREQ = 6'd32, TK_DOT = 6'd33, TK_SHARP = 6'd34,
    TK_SQL = 6'd35, TK_SQR = 6'd36, TK_AMP = 6'd37
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_UNEXPECTED = 3'd0, ERR_NL_IN_STR = 3'd1, ERR_END_IN_STR = 3'd2,
    ERR_BAD_ESCAPE = 3'd3, ERR_TOO_LONG = 3'd4
  } err_code_e;

  typedef enum logic [1:0] {
    VAL_ZERO, VAL_ACC, VAL_LEN
  } val_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        capture;
    logic        line_inc;
    logic        emit;
    token_kind_e emit_kind;
    err_code_e   emit_err;
    logic        emit_cur_line;
    val_sel_e    emit_val;
    logic        emit_run;
    logic        append;
    logic        append_esc;
    logic        text_init;
    logic        text_clear;
    logic        acc_load;
    logic        acc_step;
    logic        start_load;
    logic        flush_start;
    logic        flush_step;
  } sts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       src_kind;
    logic [7:0] src_byte;
    logic       out_free;
    logic       text_full;
    logic       text_empty;
    logic       run_last;
    logic       kw_hit;
    logic [2:0] kw_idx;
  } sts_status_t;

  localparam logic [39:0] KW_TEXT [KW_NUM] =
    '{"do", "begin", "end", "if", "then", "else", "def", "let"};
  localparam logic [2:0] KW_LEN [KW_NUM] =
    '{3'd2, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd3};

  // Character of keyword k at position pos, zero past its end.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [LEN_W-1:0] pos);
    int n;
    int p;
    n = int'(KW_LEN[k]);
    p = int'(pos);
    if (p >= n) return 8'h00;
    return KW_TEXT[k][(n - 1 - p) * 8 +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_ident(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == "_") || (b == "!") || (b == "?");
  endfunction

  // Single-character punctuators; TK_ERROR means none.
  function automatic token_kind_e single_punct(input logic [7:0] b);
    unique case (b)
      ".": return TK_DOT;
      "(": return TK_LPAR;
      ")": return TK_RPAR;
      ":": return TK_COLON;
      ",": return TK_COMMA;
      "|": return TK_PIPE;
      "+": return TK_PLUS;
      "-": return TK_MINUS;
      "*": return TK_STAR;
      "/": return TK_SLASH;
      "#": return TK_SHARP;
      "[": return TK_SQL;
      "]": return TK_SQR;
      "&": return TK_AMP;
      default: return TK_ERROR;
    endcase
  endfunction

  // Escape decode; bit 8 set marks an invalid escape.
  function automatic logic [8:0] unescape(input logic [7:0] b);
    unique case (b)
      "\\": return 9'h05C;
      "\"": return 9'h022;
      "t": return 9'h009;
      "a": return 9'h007;
      "b": return 9'h008;
      "n": return 9'h00A;
      "r": return 9'h00D;
      "v": return 9'h00B;
      "f": return 9'h00C;
      default: return 9'h100;
    endcase
  endfunction

endpackage

// File: rtl/sts_datapath.sv
// Datapath of the source token scanner: item capture, counters, text store, result register.
module sts_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sts_pkg::sts_cmd_t   cmd_i,
  output sts_pkg::sts_status_t status_o,
  input  logic                in_kind_i,
  input  logic [7:0]          in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [5:0]          out_kind_o,
  output logic [15:0]         out_line_o,
  output logic [30:0]         out_int_o,
  output logic [7:0]          out_text_o,
  output logic [2:0]          out_err_o,
  output logic                out_last_o
);
  import sts_pkg::*;

  logic             kind_q;
  logic [7:0]       byte_q;
  logic [LINE_W-1:0] line_q, start_q;
  logic [INT_W-1:0] acc_q;
  logic [LEN_W-1:0] len_q;
  logic [IDX_W-1:0] idx_q;
  logic [7:0]       store_q [MAX_TEXT];
  logic [KW_NUM-1:0] kw_ok_q;

  logic             out_valid_q, out_last_q;
  logic [5:0]       out_kind_q;
  logic [LINE_W-1:0] out_line_q;
  logic [INT_W-1:0] out_int_q;
  logic [7:0]       out_text_q;
  logic [2:0]       out_err_q;

  logic [7:0]       app_byte;
  logic [8:0]       esc;
  logic [34:0]      acc_ext, acc_next;
  logic             run_last;
  logic             kw_hit;
  logic [2:0]       kw_idx;
  logic             out_free;

  assign esc      = unescape(byte_q);
  assign app_byte = cmd_i.append_esc ? esc[7:0] : byte_q;
  assign acc_ext  = {4'b0, acc_q};
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {31'b0, byte_q[3:0]};
  assign run_last = ({1'b0, idx_q} + LEN_W'(1)) == len_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Keyword lookup over the incrementally tracked match bits.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (kw_ok_q[k] && (len_q == LEN_W'(KW_LEN[k]))) begin
        kw_hit = 1'b1;
        kw_idx = 3'(k);
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      byte_q <= in_byte_i;
    end
  end

  // Line counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= LINE_W'(1);
      start_q <= LINE_W'(1);
    end else begin
      if (cmd_i.line_inc && (byte_q == 8'h0A) && (line_q != '1)) line_q <= line_q + LINE_W'(1);
      if (cmd_i.start_load) start_q <= line_q;
    end
  end

  // Number accumulator with saturation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.acc_load) begin
      acc_q <= {27'b0, byte_q[3:0]};
    end else if (cmd_i.acc_step) begin
      acc_q <= (acc_next > {4'b0, {INT_W{1'b1}}}) ? '1 : acc_next[INT_W-1:0];
    end
  end

  // Text length, flush index and keyword match bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      idx_q   <= '0;
      kw_ok_q <= '0;
    end else begin
      if (cmd_i.text_clear) len_q <= '0;
      if (cmd_i.text_init) begin
        len_q <= LEN_W'(1);
        for (int k = 0; k < KW_NUM; k++) kw_ok_q[k] <= kw_char(3'(k), '0) == byte_q;
      end
      if (cmd_i.append) begin
        len_q <= len_q + LEN_W'(1);
        for (int k = 0; k < KW_NUM; k++) begin
          kw_ok_q[k] <= kw_ok_q[k] && (kw_char(3'(k), len_q) == app_byte);
        end
      end
      if (cmd_i.flush_start) idx_q <= '0;
      if (cmd_i.flush_step) idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Text store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.text_init) store_q[0] <= byte_q;
    if (cmd_i.append) store_q[len_q[IDX_W-1:0]] <= app_byte;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_line_q <= cmd_i.emit_cur_line ? line_q : start_q;
      out_err_q  <= cmd_i.emit_err;
      unique case (cmd_i.emit_val)
        VAL_ACC: out_int_q <= acc_q;
        VAL_LEN: out_int_q <= INT_W'(len_q);
        default: out_int_q <= '0;
      endcase
      out_text_q <= cmd_i.emit_run ? store_q[idx_q] : 8'h00;
      out_last_q <= cmd_i.emit_run ? run_last : 1'b1;
    end
  end

  assign status_o = '{src_kind: kind_q, src_byte: byte_q, out_free: out_free,
                      text_full: len_q >= LEN_W'(MAX_TEXT), text_empty: len_q == '0,
                      run_last: run_last, kw_hit: kw_hit, kw_idx: kw_idx};

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_line_o  = out_line_q;
  assign out_int_o   = out_int_q;
  assign out_text_o  = out_text_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/sts_ctrl.sv
// Controller of the source token scanner: scan mode and token sequencing.
module sts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sts_pkg::sts_status_t status_i,
  output sts_pkg::sts_cmd_t    cmd_o
);
  import sts_pkg::*;

  typedef enum logic [5:0] {
    ST_WAIT   = 6'b000001,
    ST_BOF    = 6'b000010,
    ST_FIRST  = 6'b000100,
    ST_FLUSH  = 6'b001000,
    ST_SECOND = 6'b010000,
    ST_EOF    = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    M_START, M_IDLE, M_IDENT, M_INT, M_STR, M_ESC, M_EQ, M_BANG, M_LT, M_GT,
    M_DONE, M_ERR
  } scan_mode_e;

  state_e     state_q, state_d;
  state_e     follow_q, follow_d;
  scan_mode_e mode_q, mode_d;
  sts_cmd_t   cmd;
  logic [7:0] b;
  logic [8:0] esc;
  token_kind_e punct;

  assign b     = status_i.src_byte;
  assign esc   = unescape(b);
  assign punct = single_punct(b);
  assign in_ready_o = state_q == ST_WAIT;

  always_comb begin
    cmd      = '0;
    state_d  = state_q;
    follow_d = follow_q;
    mode_d   = mode_q;
    unique case (state_q)
      // Take an item; silent once finished or failed.
      ST_WAIT: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          if (mode_q == M_START) state_d = ST_BOF;
          else if (mode_q != M_DONE && mode_q != M_ERR) state_d = ST_FIRST;
        end
      end
      // Begin token ahead of the first item.
      ST_BOF: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = TK_BOF;
          cmd.emit_cur_line = 1'b1;
          mode_d = M_IDLE;
          state_d = ST_FIRST;
        end
      end
      // Continue or finish the token in progress.
      ST_FIRST: begin
        if (status_i.out_free) begin
          cmd.line_inc = !status_i.src_kind;
          state_d = status_i.src_kind ? ST_EOF : ST_SECOND;
          unique case (mode_q)
            M_IDENT: begin
              if (!status_i.src_kind && is_ident(b)) begin
                state_d = ST_WAIT;
                if (status_i.text_full) begin
                  cmd.emit = 1'b1;
                  cmd.emit_kind = TK_ERROR;
                  cmd.emit_err = ERR_TOO_LONG;
                  mode_d = M_ERR;
                end else begin
                  cmd.append = 1'b1;
                end
              end else if (status_i.kw_hit) begin
                cmd.emit = 1'b1;
                cmd.emit_kind = token_kind_e'(6'(TK_DO) + {3'b0, status_i.kw_idx});
              end else begin
                cmd.flush_start = 1'b1;
                follow_d = state_d;
                state_d = ST_FLUSH;
              end
            end
            M_INT: begin
              if (!status_i.src_kind && is_digit(b)) begin
                cmd.acc_step = 1'b1;
                state_d = ST_WAIT;
              end else begin
                cmd.emit = 1'b1;
                cmd.emit_kind = TK_INTEGER;
                cmd.emit_val = VAL_ACC;
              end
            end
            M_EQ, M_LT, M_GT: begin
              cmd.emit = 1'b1;
              cmd.emit_kind = (mode_q == M_EQ) ? TK_ASSIGN :
                              (mode_q == M_LT) ? TK_LESS : TK_GREATER;
              if (!status_i.src_kind) begin
                if (b == "=") begin
                  cmd.emit_kind = (mode_q == M_EQ) ? TK_EQUAL :
                                  (mode_q == M_LT) ? TK_LESSEQ : TK_GREATEREQ;
                  mode_d = M_IDLE;
                  state_d = ST_WAIT;
                end else if (mode_q == M_LT && b == "<") begin
                  cmd.emit_kind = TK_LQUOTE;
                  mode_d = M_IDLE;
                  state_d = ST_WAIT;
                end else if (mode_q == M_GT && b == ">") begin
                  cmd.emit_kind = TK_RQUOTE;
                  mode_d = M_IDLE;
                  state_d = ST_WAIT;
                end
              end
            end
            M_BANG: begin
              cmd.emit = 1'b1;
              state_d = ST_WAIT;
              if (!status_i.src_kind && b == "=") begin
                cmd.emit_kind = TK_NOTEQ;
                mode_d = M_IDLE;
              end else begin
                cmd.emit_kind = TK_ERROR;
                cmd.emit_err = ERR_UNEXPECTED;
                mode_d = M_ERR;
              end
            end
            M_STR, M_ESC: begin
              state_d = ST_WAIT;
              if (status_i.src_kind) begin
                cmd.emit = 1'b1;
                cmd.emit_kind = TK_ERROR;
                cmd.emit_err = ERR_END_IN_STR;
                mode_d = M_ERR;
              end else if (b == 8'h0A) begin
                cmd.emit = 1'b1;
                cmd.emit_kind = TK_ERROR;
                cmd.emit_err = ERR_NL_IN_STR;
                mode_d = M_ERR;
              end else if (mode_q == M_ESC && esc[8]) begin
                cmd.emit = 1'b1;
                cmd.emit_kind = TK_ERROR;
                cmd.emit_err = ERR_BAD_ESCAPE;
                mode_d = M_ERR;
              end else if (mode_q == M_STR && b == "\"") begin
                mode_d = M_IDLE;
                if (status_i.text_empty) begin
                  cmd.emit = 1'b1;
                  cmd.emit_kind = TK_STRING;
                  cmd.emit_val = VAL_LEN;
                end else begin
                  cmd.flush_start = 1'b1;
                  follow_d = ST_WAIT;
                  state_d = ST_FLUSH;
                end
              end else if (mode_q == M_STR && b == "\\") begin
                mode_d = M_ESC;
              end else if (status_i.text_full) begin
                cmd.emit = 1'b1;
                cmd.emit_kind = TK_ERROR;
                cmd.emit_err = ERR_TOO_LONG;
                mode_d = M_ERR;
              end else begin
                cmd.append = 1'b1;
                cmd.append_esc = mode_q == M_ESC;
                mode_d = M_STR;
              end
            end
            default: ;
          endcase
        end
      end
      // Text run of an identifier or string, one byte per result.
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_run = 1'b1;
          cmd.emit_kind = (mode_q == M_IDENT) ? TK_IDENT : TK_STRING;
          cmd.emit_val = VAL_LEN;
          if (status_i.run_last) begin
            state_d = follow_q;
            if (mode_q == M_IDENT) mode_d = M_IDLE;
          end else begin
            cmd.flush_step = 1'b1;
          end
        end
      end
      // Start a new token with the current byte.
      ST_SECOND: begin
        if (status_i.out_free) begin
          cmd.start_load = 1'b1;
          mode_d = M_IDLE;
          state_d = ST_WAIT;
          cmd.emit_cur_line = 1'b1;
          if (b == " " || b == 8'h09) begin
            mode_d = M_IDLE;
          end else if (b == 8'h0A) begin
            cmd.emit = 1'b1;
            cmd.emit_kind = TK_EOL;
          end else if (punct != TK_ERROR) begin
            cmd.emit = 1'b1;
            cmd.emit_kind = punct;
          end else if (b == "=") begin
            mode_d = M_EQ;
          end else if (b == "!") begin
            mode_d = M_BANG;
          end else if (b == "<") begin
            mode_d = M_LT;
          end else if (b == ">") begin
            mode_d = M_GT;
          end else if (b == "\"") begin
            mode_d = M_STR;
            cmd.text_clear = 1'b1;
          end else if (is_digit(b)) begin
            mode_d = M_INT;
            cmd.acc_load = 1'b1;
          end else if (is_alpha(b) || b == "_") begin
            mode_d = M_IDENT;
            cmd.text_init = 1'b1;
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_kind = TK_ERROR;
            cmd.emit_err = ERR_UNEXPECTED;
            mode_d = M_ERR;
          end
        end
      end
      // End token.
      ST_EOF: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = TK_EOF;
          cmd.emit_cur_line = 1'b1;
          mode_d = M_DONE;
          state_d = ST_WAIT;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WAIT;
      follow_q <= ST_WAIT;
      mode_q   <= M_START;
    end else begin
      state_q  <= state_d;
      follow_q <= follow_d;
      mode_q   <= mode_d;
    end
  end

  assign cmd_o = cmd;

endmodule

// File: rtl/source_token_scanner_core.sv
// Top level of the source token scanner.
// The scanner takes one source byte or end-of-input request at a time and returns tokens as
// stream requests. A byte that continues or completes the current token goes through capture,
// then the token step. A byte that starts a token, separates tokens, or ends a token without
// belonging to it goes on to a further step of its own, in which the new token is opened. End
// of input goes on to the end-token step instead, and the very first item first passes the
// begin-token step. An identifier or string that comes out as text holds input while the
// controller walks the text store, one entry per cycle whenever the output register is free.
// The token steps wait while the output register holds a result that has not been taken, and
// no input is accepted meanwhile. After an error or the end token the scanner accepts and
// drops every request until reset.
module source_token_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] token_line, [46:16] int_value,
                                      // [54:47] text_byte, [57:55] error_code, rest zero
  output logic [5:0]  m_axis_tuser,   // [5:0] token_kind
  output logic        m_axis_tlast    // last
);
  import sts_pkg::*;
`include "source_token_scanner_core_defines.svh"

  sts_cmd_t    cmd;
  sts_status_t status;
  logic [15:0] line;
  logic [30:0] ival;
  logic [7:0]  text;
  logic [2:0]  err;

  sts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sts_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_kind_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_line_o  (line),
    .out_int_o   (ival),
    .out_text_o  (text),
    .out_err_o   (err),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, err, text, ival, line};

  // An error token is the final result; nothing follows it.
  `STS_ASSERT(a_silent_after_error, (m_axis_tvalid && m_axis_tready && m_axis_tuser == TK_ERROR) |=> !m_axis_tvalid, "result after error token")
  // Only text runs have results that are not last.
  `STS_ASSERT(a_run_kind, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == TK_IDENT || m_axis_tuser == TK_STRING), "non-last result outside a text run")
  // A text run always carries its nonzero length.
  `STS_ASSERT(a_run_len, (m_axis_tvalid && !m_axis_tlast) |-> (ival != '0), "text run with zero length")
  // No result is emitted while the controller waits for input.
  `STS_ASSERT_ALWAYS(a_ready_vs_emit, s_axis_tready |-> !cmd.emit, "emission while waiting for input")

endmodule
